[rtl/assert_macros.svh]
// Assertion macros for the gap buffer RTL.
// Needs nothing but a clock and an active-low reset at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gbuf_pkg.sv]
// Shared types and constants for the gap buffer text store.
// No dependencies.
package gbuf_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int PTR_W    = 11;
  localparam int CHAR_W   = 8;
  localparam int FUNC_W   = 3;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_DELETE    = 3'd1,
    OP_BACKSPACE = 3'd2,
    OP_LEFT      = 3'd3,
    OP_RIGHT     = 3'd4
  } op_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] ch;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [PTR_W-1:0]  cursor_pos;
    logic [PTR_W-1:0]  char_count;
    logic [CHAR_W-1:0] char_before_cursor;
  } out_item_t;

  // Pointer state kept in flops beside the text RAM.
  typedef struct packed {
    logic [PTR_W-1:0]  cursor;
    logic [PTR_W-1:0]  gap_end;
    logic [PTR_W-1:0]  total;
    logic [CHAR_W-1:0] cb;       // character left of the cursor, 0 at start
  } gbuf_state_t;

  typedef struct packed {
    logic              ok;
    gbuf_state_t       nxt;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
  } edit_res_t;

endpackage

[rtl/gbuf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gbuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/gbuf_edit.sv]
// Edit datapath: next pointers, RAM write request and result flag for one edit.
// Depends on gbuf_pkg.
module gbuf_edit (
  input  logic [gbuf_pkg::FUNC_W-1:0] func_i,
  input  logic [gbuf_pkg::CHAR_W-1:0] ch_i,
  input  gbuf_pkg::gbuf_state_t       cur_i,
  input  logic [gbuf_pkg::CHAR_W-1:0] rdata_i,
  output gbuf_pkg::edit_res_t         res_o
);

  localparam logic [gbuf_pkg::PTR_W-1:0] CapPtr = gbuf_pkg::PTR_W'(gbuf_pkg::CAPACITY);
  localparam logic [gbuf_pkg::PTR_W-1:0] One    = gbuf_pkg::PTR_W'(1);

  logic gap_open;
  logic tail_left;
  logic cur_nz;
  logic cur_one;
  logic [gbuf_pkg::CHAR_W-1:0] cb_after_dec;

  assign gap_open  = cur_i.cursor < cur_i.gap_end;
  assign tail_left = cur_i.gap_end < CapPtr;
  assign cur_nz    = cur_i.cursor != '0;
  assign cur_one   = cur_i.cursor == One;
  // Cursor stepping back to zero leaves nothing to its left.
  assign cb_after_dec = cur_one ? '0 : rdata_i;

  always_comb begin
    res_o       = '0;
    res_o.nxt   = cur_i;
    res_o.waddr = cur_i.cursor[gbuf_pkg::ADDR_W-1:0];
    res_o.wdata = ch_i;
    unique case (gbuf_pkg::op_e'(func_i))
      gbuf_pkg::OP_INSERT: begin
        if (gap_open) begin
          res_o.ok         = 1'b1;
          res_o.we         = 1'b1;
          res_o.nxt.cursor = cur_i.cursor + One;
          res_o.nxt.total  = cur_i.total + One;
          res_o.nxt.cb     = ch_i;
        end
      end
      gbuf_pkg::OP_DELETE: begin
        if (tail_left) begin
          res_o.ok          = 1'b1;
          res_o.nxt.gap_end = cur_i.gap_end + One;
          res_o.nxt.total   = cur_i.total - One;
        end
      end
      gbuf_pkg::OP_BACKSPACE: begin
        if (cur_nz) begin
          res_o.ok         = 1'b1;
          res_o.nxt.cursor = cur_i.cursor - One;
          res_o.nxt.total  = cur_i.total - One;
          res_o.nxt.cb     = cb_after_dec;
        end
      end
      gbuf_pkg::OP_LEFT: begin
        // Char left of cursor is already held in cb; copy it to the gap end.
        if (cur_nz) begin
          res_o.ok          = 1'b1;
          res_o.we          = 1'b1;
          res_o.waddr       = gbuf_pkg::ADDR_W'(cur_i.gap_end - One);
          res_o.wdata       = cur_i.cb;
          res_o.nxt.cursor  = cur_i.cursor - One;
          res_o.nxt.gap_end = cur_i.gap_end - One;
          res_o.nxt.cb      = cb_after_dec;
        end
      end
      gbuf_pkg::OP_RIGHT: begin
        if (tail_left) begin
          res_o.ok          = 1'b1;
          res_o.we          = 1'b1;
          res_o.wdata       = rdata_i;
          res_o.nxt.cursor  = cur_i.cursor + One;
          res_o.nxt.gap_end = cur_i.gap_end + One;
          res_o.nxt.cb      = rdata_i;
        end
      end
      default: begin
        res_o.ok = 1'b0;
      end
    endcase
  end

endmodule

[rtl/gap_buffer_text_editor_store_unit.sv]
// Gap buffer text store: one edit per input transfer, one result per edit.
// Input channel in_*: valid/stall, payload gbuf_pkg::in_item_t {func, ch}.
//   func: insert, delete forward, backspace, cursor left, cursor right.
// Output channel out_*: valid/stall, payload gbuf_pkg::out_item_t
//   {ok, cursor_pos, char_count, char_before_cursor}.
// An edit is handled in idle and then execute: the accept cycle issues one read of the text
// RAM (cursor-2, or gap end for a right move); in execute the block uses the
// registered read data, writes at most one RAM entry and loads the result
// register, which ends the edit. The block takes no new edit until the last
// one has left execute, as each edit makes a single read-then-write RAM pass.
// in_stall_o is high while an edit is in flight.
// The character left of the cursor is kept in a flop so a left move needs
// only one read. When out_stall_i holds a finished result, the block can
// still take the next edit; that edit then waits in execute until the
// result register frees up.
// Reset (rst_ni low, async): cursor and count to zero, gap end to capacity,
// no result pending. The RAM is not cleared; no edit uses the data of an unwritten entry.
// Depends on gbuf_pkg, gbuf_ram, gbuf_edit, assert_macros.svh.
`include "assert_macros.svh"

module gap_buffer_text_editor_store_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gbuf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gbuf_pkg::out_item_t out_data_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                      state_q, state_d;
  gbuf_pkg::gbuf_state_t       ptr_q, ptr_d;
  logic [gbuf_pkg::FUNC_W-1:0] func_q;
  logic [gbuf_pkg::CHAR_W-1:0] ch_q;
  logic                        out_valid_q, out_valid_d;
  gbuf_pkg::out_item_t         out_data_q;

  logic                        in_xfer;
  logic                        done;
  logic [gbuf_pkg::ADDR_W-1:0] raddr;
  logic [gbuf_pkg::CHAR_W-1:0] rdata;
  gbuf_pkg::edit_res_t         edit;

  assign in_stall_o = state_q != S_IDLE;
  assign in_xfer    = in_valid_i && !in_stall_o;
  // Result register is free when empty or being drained this cycle.
  assign done       = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  // Right move reads the first char past the gap; everything else wants
  // the char that will sit left of a decremented cursor.
  always_comb begin
    if (gbuf_pkg::op_e'(in_data_i.func) == gbuf_pkg::OP_RIGHT) begin
      raddr = ptr_q.gap_end[gbuf_pkg::ADDR_W-1:0];
    end else begin
      raddr = gbuf_pkg::ADDR_W'(ptr_q.cursor - gbuf_pkg::PTR_W'(2));
    end
  end

  gbuf_ram #(
    .WIDTH (gbuf_pkg::CHAR_W),
    .DEPTH (gbuf_pkg::CAPACITY)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (done && edit.we),
    .waddr_i (edit.waddr),
    .wdata_i (edit.wdata),
    .re_i    (in_xfer),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  gbuf_edit u_edit (
    .func_i  (func_q),
    .ch_i    (ch_q),
    .cur_i   (ptr_q),
    .rdata_i (rdata),
    .res_o   (edit)
  );

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          state_d     = S_IDLE;
          ptr_d       = edit.nxt;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ptr_q.cursor  <= '0;
      ptr_q.gap_end <= gbuf_pkg::PTR_W'(gbuf_pkg::CAPACITY);
      ptr_q.total   <= '0;
      ptr_q.cb      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= in_data_i.func;
      ch_q   <= in_data_i.ch;
    end
    if (done) begin
      out_data_q.ok                 <= edit.ok;
      out_data_q.cursor_pos         <= edit.nxt.cursor;
      out_data_q.char_count         <= edit.nxt.total;
      out_data_q.char_before_cursor <= edit.nxt.cb;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_IMP(a_count_matches, clk_i, rst_ni, 1'b1,
    ptr_q.total == ptr_q.cursor + (gbuf_pkg::PTR_W'(gbuf_pkg::CAPACITY) - ptr_q.gap_end),
    "char count disagrees with cursor and gap end")
  `ASSERT_IMP(a_cursor_in_gap, clk_i, rst_ni, 1'b1,
    ptr_q.cursor <= ptr_q.gap_end, "cursor past gap end")
  `ASSERT_NXT(a_accept_to_exec, clk_i, rst_ni, in_xfer,
    state_q == S_EXEC && in_stall_o, "accepted edit did not enter execute")
  `ASSERT_IMP(a_ptrs_held, clk_i, rst_ni, state_q == S_IDLE,
    ptr_d == ptr_q, "pointers changed outside execute")

endmodule

[dv/gap_buffer_text_editor_store_unit_test.sv]
// Self-checking bench for the gap buffer text store: edit streams in, one report per edit out.
// A text mirror predicts every report; both channels idle and stall at random.
// Depends on gbuf_pkg and the gap_buffer_text_editor_store_unit RTL.
`timescale 1ns / 100ps

module gap_buffer_text_editor_store_unit_test;
  import gbuf_pkg::*;

  // Codes above OP_RIGHT are unassigned; the block reports them as refused.
  localparam int unsigned UNUSED_FUNCS = 3;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  // Set for stretches of edits with no sender gaps and no receiver stalls.
  bit          steady_run = 1'b0;
  int unsigned edits_sent = 0;

  // Mirror of the text store: same pointers, same array, one report queued per
  // accepted edit, reports checked in order.
  class gap_text_mirror;
    logic [CHAR_W-1:0] text_mem [CAPACITY];
    int unsigned       cursor_at;
    int unsigned       gap_end_at;
    int unsigned       chars_held;
    out_item_t         reports_q [$];
    int unsigned       errors;

    function new();
      cursor_at  = 0;
      gap_end_at = CAPACITY;
      chars_held = 0;
      errors     = 0;
    endfunction

    // Apply one edit and queue the report it must produce.
    function void take_edit(in_item_t e);
      out_item_t r;
      r = '0;
      case (e.func)
        OP_INSERT: begin
          if (cursor_at < gap_end_at) begin
            text_mem[cursor_at] = e.ch;
            cursor_at++;
            chars_held++;
            r.ok = 1'b1;
          end
        end
        OP_DELETE: begin
          if (gap_end_at < CAPACITY) begin
            gap_end_at++;
            chars_held--;
            r.ok = 1'b1;
          end
        end
        OP_BACKSPACE: begin
          if (cursor_at > 0) begin
            cursor_at--;
            chars_held--;
            r.ok = 1'b1;
          end
        end
        OP_LEFT: begin
          if (cursor_at > 0) begin
            cursor_at--;
            gap_end_at--;
            text_mem[gap_end_at] = text_mem[cursor_at];
            r.ok = 1'b1;
          end
        end
        OP_RIGHT: begin
          if (gap_end_at < CAPACITY) begin
            text_mem[cursor_at] = text_mem[gap_end_at];
            cursor_at++;
            gap_end_at++;
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
      r.cursor_pos         = PTR_W'(cursor_at);
      r.char_count         = PTR_W'(chars_held);
      r.char_before_cursor = (cursor_at > 0) ? text_mem[cursor_at - 1] : '0;
      reports_q.push_back(r);
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (reports_q.size() == 0) begin
        errors++;
        $error("report with no edit outstanding: %h", got);
        return;
      end
      want = reports_q.pop_front();
      if (got.ok !== want.ok) begin
        errors++;
        $error("ok: expected %0d, got %0d", want.ok, got.ok);
      end
      if (got.cursor_pos !== want.cursor_pos) begin
        errors++;
        $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, got.cursor_pos);
      end
      if (got.char_count !== want.char_count) begin
        errors++;
        $error("char_count: expected %0d, got %0d", want.char_count, got.char_count);
      end
      if (got.char_before_cursor !== want.char_before_cursor) begin
        errors++;
        $error("char_before_cursor: expected %h, got %h",
               want.char_before_cursor, got.char_before_cursor);
      end
    endfunction
  endclass

  gap_text_mirror mirror = new();

  gap_buffer_text_editor_store_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Monitors sample at the falling edge: every input and output is settled
  // there, and a channel with valid high and stall low at that point
  // completes its transfer on the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && in_valid_i && in_stall_o === 1'b0) begin
      mirror.take_edit(in_data_i);
    end
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && !out_stall_i) begin
      mirror.check_report(out_data_o);
    end
  end

  function automatic in_item_t edit_item(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] c);
    in_item_t e;
    e.func = f;
    e.ch   = c;
    return e;
  endfunction

  // Weighted draw of one edit; ch is always random so every byte bit toggles.
  function automatic in_item_t pick_edit(int unsigned w_ins, int unsigned w_del,
                                         int unsigned w_bs, int unsigned w_lft,
                                         int unsigned w_rgt, int unsigned w_bad);
    in_item_t    e;
    int unsigned roll;
    roll = $urandom_range(0, w_ins + w_del + w_bs + w_lft + w_rgt + w_bad - 1);
    e.ch = CHAR_W'($urandom_range(0, 255));
    if (roll < w_ins) begin
      e.func = OP_INSERT;
    end else if (roll < w_ins + w_del) begin
      e.func = OP_DELETE;
    end else if (roll < w_ins + w_del + w_bs) begin
      e.func = OP_BACKSPACE;
    end else if (roll < w_ins + w_del + w_bs + w_lft) begin
      e.func = OP_LEFT;
    end else if (roll < w_ins + w_del + w_bs + w_lft + w_rgt) begin
      e.func = OP_RIGHT;
    end else begin
      e.func = FUNC_W'(OP_RIGHT + 1 + $urandom_range(0, UNUSED_FUNCS - 1));
    end
    return e;
  endfunction

  // Runs at a rising edge. Returns at the edge that completes the transfer
  // with valid still high, so the next send can follow back to back; callers
  // that pause use stop_sending first. Either way valid gets one NBA per edge.
  task automatic send_edit(in_item_t e);
    int unsigned gap;
    if ((edits_sent % 48) == 0) begin
      steady_run = ($urandom_range(0, 3) == 0);
    end
    edits_sent++;
    gap = steady_run ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      in_data_i  <= in_item_t'($urandom_range(0, (1 << $bits(in_item_t)) - 1));
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= e;
    do @(negedge clk_i); while (in_stall_o !== 1'b0);
    @(posedge clk_i);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    in_data_i  <= in_item_t'($urandom_range(0, (1 << $bits(in_item_t)) - 1));
  endtask

  // Always advances at least one edge so a following send never lands on the
  // same edge as stop_sending.
  task automatic wait_reports_done();
    do @(posedge clk_i); while (mirror.reports_q.size() != 0);
  endtask

  // Receiver: per report, stall at random (not in steady runs), then take it.
  initial begin
    int unsigned hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = steady_run ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(negedge clk_i); while (out_valid_o !== 1'b1);
      @(posedge clk_i);
    end
  end

  // Main sequence.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every refusal on an empty store, unassigned codes, extreme
    // bytes, moves to both ends, refusals with text on the far side, and back
    // to empty.
    send_edit(edit_item(OP_DELETE, 8'h00));
    send_edit(edit_item(OP_BACKSPACE, 8'h00));
    send_edit(edit_item(OP_LEFT, 8'h00));
    send_edit(edit_item(OP_RIGHT, 8'h00));
    for (int unsigned k = 1; k <= UNUSED_FUNCS; k++) begin
      send_edit(edit_item(FUNC_W'(OP_RIGHT + k), 8'hFF));
    end
    send_edit(edit_item(OP_INSERT, 8'h00));
    send_edit(edit_item(OP_INSERT, 8'hFF));
    send_edit(edit_item(OP_INSERT, 8'hA5));
    repeat (4) send_edit(edit_item(OP_LEFT, 8'h00));   // last one refused at start
    send_edit(edit_item(OP_BACKSPACE, 8'h00));          // refused: cursor at start
    send_edit(edit_item(OP_RIGHT, 8'h00));
    send_edit(edit_item(OP_DELETE, 8'h00));             // drops the byte after cursor
    send_edit(edit_item(OP_RIGHT, 8'h00));
    send_edit(edit_item(OP_RIGHT, 8'h00));              // refused: at end
    send_edit(edit_item(OP_DELETE, 8'h00));             // refused: nothing after
    send_edit(edit_item(OP_BACKSPACE, 8'h00));
    send_edit(edit_item(OP_INSERT, 8'h5A));
    send_edit(edit_item(OP_BACKSPACE, 8'h00));
    send_edit(edit_item(OP_BACKSPACE, 8'h00));          // store empty again

    // Hold the sender off until the block has drained completely.
    stop_sending();
    wait_reports_done();

    // Mixed edits on a short text.
    repeat (30) send_edit(pick_edit(30, 15, 15, 15, 15, 5));

    // Fill to capacity with inserts at the cursor.
    while (mirror.chars_held < CAPACITY) begin
      send_edit(edit_item(OP_INSERT, CHAR_W'($urandom_range(0, 255))));
    end
    // Cursor to the very end of a full store, then inserts refused on an
    // empty gap, mixed with moves and unassigned codes.
    while (mirror.cursor_at < CAPACITY) begin
      send_edit(edit_item(OP_RIGHT, CHAR_W'($urandom_range(0, 255))));
    end
    repeat (20) send_edit(pick_edit(40, 0, 0, 20, 20, 20));

    stop_sending();
    wait_reports_done();

    // Trim from a full store with deletes and backspaces dominating.
    repeat (20) send_edit(pick_edit(20, 30, 30, 10, 10, 2));

    stop_sending();
    wait_reports_done();
    repeat (10) @(posedge clk_i);

    if (mirror.errors == 0 && mirror.reports_q.size() == 0) begin
      $display("gap_buffer_text_editor_store_unit test passed");
    end else begin
      $display("gap_buffer_text_editor_store_unit test failed");
    end
    $finish;
  end

  // Watchdog: ends the run with a failure if the sequence hangs.
  initial begin
    #1_500_000;
    $display("gap_buffer_text_editor_store_unit test failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/gbuf_pkg.sv
rtl/gbuf_ram.sv
rtl/gbuf_edit.sv
rtl/gap_buffer_text_editor_store_unit.sv
dv/gap_buffer_text_editor_store_unit_test.sv
